// File: hdl/timeline_animation_sequencer_defines.svh
// Assertion macros shared by the timeline animation sequencer RTL.
`ifndef TIMELINE_ANIMATION_SEQUENCER_DEFINES_SVH
`define TIMELINE_ANIMATION_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, masked during reset
`define TAS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tas assertion failed");

// Next-cycle implication, masked during reset
`define TAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tas assertion failed");

`else

`define TAS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TAS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hdl/tas_pkg.sv
// Types, codes and sizes shared by the timeline animation sequencer.
`default_nettype none

package tas_pkg;

   // Timeline table sizing
   localparam int MAX_ENTRIES = 256;
   localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int SUM_W       = 8 + CNT_W;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_TOTAL_TICKS    = 2'd0;
   localparam logic [1:0] REG_FRAME_COUNT    = 2'd1;
   localparam logic [1:0] REG_TIMELINE_COUNT = 2'd2;

   // Item kinds
   localparam logic [2:0] KIND_LOAD       = 3'd0;
   localparam logic [2:0] KIND_ACTIVATE   = 3'd1;
   localparam logic [2:0] KIND_DEACTIVATE = 3'd2;
   localparam logic [2:0] KIND_DRAW       = 3'd3;
   localparam logic [2:0] KIND_FRAME_TAIL = 3'd4;

   // Result status codes
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_INACTIVE     = 3'd1;
   localparam logic [2:0] ST_WRONG_SYSTEM = 3'd2;
   localparam logic [2:0] ST_NOT_REVEALED = 3'd3;
   localparam logic [2:0] ST_NOT_READY    = 3'd4;

   typedef enum logic {
      TAS_IDLE,
      TAS_WALK
   } tas_state_type;

   typedef struct packed {
      logic [15:0] total_ticks;
      logic [8:0]  frame_count;
      logic [8:0]  timeline_count;
   } cfg_type;

   typedef struct packed {
      logic [7:0] frame;
      logic [7:0] ticks;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic take;
      logic walk;
      logic finish;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic lookup_start;
      logic walk_done;
      logic out_busy;
   } dp_status_type;

   typedef struct packed {
      logic       show_sprite;
      logic [7:0] frame_index;
      logic       frame_changed;
      logic       hide_native;
      logic [2:0] status;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: hdl/tas_channels.sv
// Valid/ready channel interfaces for request and response words.
`default_nettype none

interface tas_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] entry_index;
   logic [7:0] entry_frame;
   logic [7:0] entry_ticks;
   logic       vanished;
   logic       system_matches;

   modport source (
      output valid, kind, entry_index, entry_frame, entry_ticks, vanished, system_matches,
      input  ready
   );
   modport sink (
      input  valid, kind, entry_index, entry_frame, entry_ticks, vanished, system_matches,
      output ready
   );
endinterface

interface tas_rsp_if;
   logic       valid;
   logic       ready;
   logic       show_sprite;
   logic [7:0] frame_index;
   logic       frame_changed;
   logic       hide_native;
   logic [2:0] status;

   modport source (
      output valid, show_sprite, frame_index, frame_changed, hide_native, status,
      input  ready
   );
   modport sink (
      input  valid, show_sprite, frame_index, frame_changed, hide_native, status,
      output ready
   );
endinterface

`default_nettype wire

// File: hdl/tas_csr.sv
// Configuration registers behind the APB-style write/read port.
`default_nettype none

module tas_csr import tas_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg        = cfg_ff;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_TOTAL_TICKS:    cfg_in.total_ticks    = csr_pwdata[15:0];
            REG_FRAME_COUNT:    cfg_in.frame_count    = csr_pwdata[8:0];
            REG_TIMELINE_COUNT: cfg_in.timeline_count = csr_pwdata[8:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         REG_TOTAL_TICKS:    csr_prdata = CSR_DATA_W'(cfg_ff.total_ticks);
         REG_FRAME_COUNT:    csr_prdata = CSR_DATA_W'(cfg_ff.frame_count);
         REG_TIMELINE_COUNT: csr_prdata = CSR_DATA_W'(cfg_ff.timeline_count);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total_ticks    <= 16'd0;
         cfg_ff.frame_count    <= 9'd1;
         cfg_ff.timeline_count <= 9'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/tas_ctrl.sv
// Controller state machine: takes words and sequences the timeline walk.
`default_nettype none

module tas_ctrl import tas_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire dp_status_type st,
   output logic               req_ready,
   output ctrl_cmd_type       cmd
);

   tas_state_type state_ff;
   tas_state_type state_in;
   logic          take;

   assign take = req_valid && req_ready;

   // Next state
   always_comb begin
      case (state_ff)
         TAS_IDLE: state_in = (take && st.lookup_start) ? TAS_WALK : TAS_IDLE;
         TAS_WALK: state_in = st.walk_done ? TAS_IDLE : TAS_WALK;
         default:  state_in = TAS_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready  = 1'b0;
      cmd.walk   = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         TAS_IDLE: req_ready = !st.out_busy;
         TAS_WALK: begin
            cmd.walk   = 1'b1;
            cmd.finish = st.walk_done;
         end
         default: req_ready = 1'b0;
      endcase
      cmd.take = req_valid && req_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TAS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/tas_datapath.sv
// Datapath: player state, timeline memory, lookup walk and response register.
`default_nettype none

module tas_datapath import tas_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ctrl_cmd_type cmd,
   input  wire cfg_type      cfg,
   input  wire logic [2:0]   req_kind,
   input  wire logic [7:0]   req_entry_index,
   input  wire logic [7:0]   req_entry_frame,
   input  wire logic [7:0]   req_entry_ticks,
   input  wire logic         req_vanished,
   input  wire logic         req_system_matches,
   input  wire logic         rsp_ready,
   output logic              rsp_valid,
   output rsp_word_type      rsp_word,
   output dp_status_type     st
);

   // Player state
   logic        armed_ff, armed_in;
   logic        revealed_ff, revealed_in;
   logic        saw_hidden_ff, saw_hidden_in;
   logic        ready_ff, ready_in;
   logic [15:0] tick_ff, tick_in;
   logic [7:0]  last_frame_ff, last_frame_in;
   logic        last_valid_ff, last_valid_in;

   // Walk state
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] chk_idx_ff, chk_idx_in;
   logic             chk_valid_ff, chk_valid_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   entry_type        rd_entry_ff;

   // Response register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   entry_type entry_mem [MAX_ENTRIES];

   logic             mem_we;
   logic [CNT_W-1:0] used_n;
   logic [CNT_W-1:0] last_idx;
   logic [15:0]      total_eff;
   logic [16:0]      tick_inc;
   logic [15:0]      next_tick;
   logic [SUM_W-1:0] sum_next;
   logic             hit;
   logic [7:0]       frame_sel;
   logic             out_load;

   // Entries in use, clamped to one and to the table depth
   always_comb begin
      if (cfg.timeline_count == '0) begin
         used_n = CNT_W'(1);
      end else if (32'(cfg.timeline_count) > MAX_ENTRIES) begin
         used_n = CNT_W'(MAX_ENTRIES);
      end else begin
         used_n = CNT_W'(cfg.timeline_count);
      end
   end
   assign last_idx = used_n - CNT_W'(1);

   // Tick advance with wrap; a total of zero acts as one
   assign total_eff = (cfg.total_ticks == '0) ? 16'd1 : cfg.total_ticks;
   assign tick_inc  = {1'b0, tick_ff} + 17'd1;
   assign next_tick = (tick_inc >= {1'b0, total_eff}) ? 16'd0 : tick_inc[15:0];

   // Walk compare on the entry read last cycle
   assign sum_next  = sum_ff + SUM_W'(rd_entry_ff.ticks);
   assign hit       = SUM_W'(tick_ff) < sum_next;
   assign frame_sel = ({1'b0, rd_entry_ff.frame} < cfg.frame_count) ? rd_entry_ff.frame : 8'd0;

   assign st.walk_done    = chk_valid_ff && (hit || (chk_idx_ff == last_idx));
   assign st.lookup_start = (req_kind == KIND_FRAME_TAIL) && armed_ff && revealed_ff
                            && ready_ff;
   assign st.out_busy     = rsp_valid_ff && !rsp_ready;

   assign mem_we = cmd.take && (req_kind == KIND_LOAD) && (32'(req_entry_index) < MAX_ENTRIES);

   // Timeline memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[ADDR_W'(req_entry_index)] <= {req_entry_frame, req_entry_ticks};
      end
      rd_entry_ff <= entry_mem[rd_idx_ff[ADDR_W-1:0]];
   end

   // Walk counters: issue one read per cycle, check one behind
   always_comb begin
      rd_idx_in    = rd_idx_ff;
      chk_idx_in   = chk_idx_ff;
      chk_valid_in = chk_valid_ff;
      sum_in       = sum_ff;
      if (cmd.take) begin
         rd_idx_in    = '0;
         chk_valid_in = 1'b0;
         sum_in       = '0;
      end else if (cmd.walk) begin
         if (rd_idx_ff < last_idx) begin
            rd_idx_in = rd_idx_ff + CNT_W'(1);
         end
         chk_idx_in   = rd_idx_ff;
         chk_valid_in = 1'b1;
         if (chk_valid_ff) begin
            sum_in = sum_next;
         end
      end
   end

   // Player state update and response word
   always_comb begin
      armed_in      = armed_ff;
      revealed_in   = revealed_ff;
      saw_hidden_in = saw_hidden_ff;
      ready_in      = ready_ff;
      tick_in       = tick_ff;
      last_frame_in = last_frame_ff;
      last_valid_in = last_valid_ff;
      rsp_word_in   = '0;
      out_load      = 1'b0;
      if (cmd.take) begin
         out_load = 1'b1;
         case (req_kind)
            KIND_LOAD: out_load = 1'b1;
            KIND_ACTIVATE: begin
               armed_in      = 1'b1;
               revealed_in   = 1'b0;
               saw_hidden_in = 1'b0;
               ready_in      = 1'b0;
               tick_in       = '0;
               last_valid_in = 1'b0;
            end
            KIND_DEACTIVATE: begin
               armed_in      = 1'b0;
               revealed_in   = 1'b0;
               saw_hidden_in = 1'b0;
               ready_in      = 1'b0;
               tick_in       = '0;
               last_valid_in = 1'b0;
            end
            KIND_DRAW: begin
               if (!armed_ff) begin
                  rsp_word_in.status = ST_INACTIVE;
               end else if (!req_system_matches) begin
                  rsp_word_in.status = ST_WRONG_SYSTEM;
               end else if (revealed_ff) begin
                  ready_in                = 1'b1;
                  rsp_word_in.hide_native = 1'b1;
               end else begin
                  saw_hidden_in = saw_hidden_ff | req_vanished;
                  if (!saw_hidden_in || req_vanished) begin
                     ready_in           = 1'b0;
                     tick_in            = next_tick;
                     rsp_word_in.status = ST_NOT_REVEALED;
                  end else begin
                     revealed_in             = 1'b1;
                     ready_in                = 1'b1;
                     rsp_word_in.hide_native = 1'b1;
                  end
               end
            end
            KIND_FRAME_TAIL: begin
               if (!armed_ff) begin
                  rsp_word_in.status = ST_INACTIVE;
               end else if (!revealed_ff) begin
                  rsp_word_in.status = ST_NOT_REVEALED;
               end else if (!ready_ff) begin
                  rsp_word_in.status = ST_NOT_READY;
               end else begin
                  // hold the response until the walk ends
                  out_load = 1'b0;
               end
            end
            default: out_load = 1'b1;
         endcase
      end else if (cmd.finish) begin
         out_load                  = 1'b1;
         rsp_word_in.show_sprite   = 1'b1;
         rsp_word_in.frame_index   = frame_sel;
         rsp_word_in.frame_changed = !last_valid_ff || (last_frame_ff != frame_sel);
         rsp_word_in.status        = ST_OK;
         last_frame_in             = frame_sel;
         last_valid_in             = 1'b1;
         tick_in                   = next_tick;
      end
   end

   // Response valid: load wins over drain
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff      <= 1'b0;
         revealed_ff   <= 1'b0;
         saw_hidden_ff <= 1'b0;
         ready_ff      <= 1'b0;
         tick_ff       <= '0;
         last_frame_ff <= '0;
         last_valid_ff <= 1'b0;
         chk_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         armed_ff      <= armed_in;
         revealed_ff   <= revealed_in;
         saw_hidden_ff <= saw_hidden_in;
         ready_ff      <= ready_in;
         tick_ff       <= tick_in;
         last_frame_ff <= last_frame_in;
         last_valid_ff <= last_valid_in;
         chk_valid_ff  <= chk_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      chk_idx_ff <= chk_idx_in;
      sum_ff     <= sum_in;
      if (out_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/timeline_animation_sequencer.sv
// Top level of the keyframe animation timeline sequencer.
//
//   Channel   Dir   Protocol        Payload
//   req_if    in    valid/ready     kind, entry fields, vanished, system_matches
//   rsp_if    out   valid/ready     show_sprite, frame_index, frame_changed,
//                                   hide_native, status
//   csr_*     in    APB-style       total_ticks, frame_count, timeline_count
//
// Load, activate, deactivate, draw and non-playing frame-tail words are answered
// from the response register in the cycle after they are taken. A playing frame-tail
// word walks the timeline memory one entry per cycle through its single read port.
// One word is in work at a time; a new word is taken while the response register
// still holds a word that is being taken. Reset is synchronous and clears the
// player state; the timeline memory is undefined until loaded.
`default_nettype none
`include "timeline_animation_sequencer_defines.svh"

module timeline_animation_sequencer import tas_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   tas_req_if.sink                    req_if,
   tas_rsp_if.source                  rsp_if,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type st;
   rsp_word_type  rsp_word;
   logic          req_ready;
   logic          rsp_valid;

   tas_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .st        (st),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   tas_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .cfg                (cfg),
      .req_kind           (req_if.kind),
      .req_entry_index    (req_if.entry_index),
      .req_entry_frame    (req_if.entry_frame),
      .req_entry_ticks    (req_if.entry_ticks),
      .req_vanished       (req_if.vanished),
      .req_system_matches (req_if.system_matches),
      .rsp_ready          (rsp_if.ready),
      .rsp_valid          (rsp_valid),
      .rsp_word           (rsp_word),
      .st                 (st)
   );

   // Drive the channels
   assign req_if.ready         = req_ready;
   assign rsp_if.valid         = rsp_valid;
   assign rsp_if.show_sprite   = rsp_word.show_sprite;
   assign rsp_if.frame_index   = rsp_word.frame_index;
   assign rsp_if.frame_changed = rsp_word.frame_changed;
   assign rsp_if.hide_native   = rsp_word.hide_native;
   assign rsp_if.status        = rsp_word.status;

   // No word taken while a response is stalled
   `TAS_ASSERT_IMPLIES(a_no_take_on_stall, clock, reset, req_if.valid && req_if.ready, !(rsp_if.valid && !rsp_if.ready))
   // No word taken during a walk
   `TAS_ASSERT_IMPLIES(a_no_take_in_walk, clock, reset, cmd.walk, !req_if.ready)
   // A finished walk presents its response next cycle
   `TAS_ASSERT_NEXT(a_finish_loads_rsp, clock, reset, cmd.finish, rsp_if.valid && rsp_if.show_sprite)
   // A shown frame always carries an ok status
   `TAS_ASSERT_IMPLIES(a_show_is_ok, clock, reset, rsp_if.valid && rsp_if.show_sprite, rsp_if.status == ST_OK)

endmodule

`default_nettype wire
